>>> src/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg: shared types, codes and helpers of the pan axis positioner
// Holds the event codes, motion modes, state and status records, and the
// wrap and clamp helpers used by the step logic.
// ----------------------------------------------------------------------------
package pap_pkg;

	localparam int unsigned POS_W  = 10;
	localparam int unsigned WIDE_W = 12;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t HALF_TURN = 12'sd180;

	// Event codes carried in the kind field
	typedef enum logic [3:0] {
		KIND_TICK      = 4'd0,
		KIND_MOVE_TO   = 4'd1,
		KIND_MOVE_BY   = 4'd2,
		KIND_RUN       = 4'd3,
		KIND_STOP      = 4'd4,
		KIND_STEP_BACK = 4'd5,
		KIND_STEP_FWD  = 4'd6,
		KIND_DIR_FWD   = 4'd7,
		KIND_DIR_BACK  = 4'd8
	} kind_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_LIMITED_MODE = 2'd0,
		REG_RANGE_LOW    = 2'd1,
		REG_RANGE_HIGH   = 2'd2
	} reg_idx_t;

	// Motion mode, one-hot
	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_CONT   = 3'b010,
		MODE_MOVETO = 3'b100
	} mode_t;

	typedef struct packed {
		pos_t  position;
		pos_t  target;
		logic  heading_fwd;
		mode_t mode;
	} axis_state_t;

	typedef struct packed {
		logic limited;
		pos_t low;
		pos_t high;
	} axis_cfg_t;

	typedef struct packed {
		pos_t position;
		logic direction_forward;
		logic moving;
		logic arrived;
	} status_t;

	localparam pos_t RANGE_LOW_RST  = -10'sd180;
	localparam pos_t RANGE_HIGH_RST = 10'sd180;

	// Reduce a value in -1080..1023 into 0..359: offset to positive, then
	// strip 1440, 720 and 360 in turn.
	function automatic pos_t wrap360(input wide_t v);
		logic signed [WIDE_W:0] s;
		logic [WIDE_W-1:0]      u;
		s = (WIDE_W+1)'(v) + 13'sd1080;
		u = s[WIDE_W-1:0];
		if (u >= 12'd1440) u = u - 12'd1440;
		if (u >= 12'd720)  u = u - 12'd720;
		if (u >= 12'd360)  u = u - 12'd360;
		return pos_t'(u[POS_W-1:0]);
	endfunction

	// Upper bound first, lower bound second: with a crossed range the low
	// bound wins.
	function automatic pos_t clamp_range(input wide_t v, input pos_t low, input pos_t high);
		wide_t r;
		r = v;
		if (r > wide_t'(high)) r = wide_t'(high);
		if (r < wide_t'(low))  r = wide_t'(low);
		return pos_t'(r[POS_W-1:0]);
	endfunction

endpackage

>>> src/pap_in_if.sv
// ----------------------------------------------------------------------------
// pap_in_if: event channel
// Carries one event beat: kind and move value, with valid and ready.
// ----------------------------------------------------------------------------
interface pap_in_if;
	logic              valid;
	logic              ready;
	logic [3:0]        kind;
	logic signed [9:0] move_value;

	modport source (output valid, kind, move_value, input ready);
	modport sink   (input valid, kind, move_value, output ready);
endinterface

>>> src/pap_out_if.sv
// ----------------------------------------------------------------------------
// pap_out_if: status channel
// Carries one status beat per event, with valid and ready.
// ----------------------------------------------------------------------------
interface pap_out_if;
	logic              valid;
	logic              ready;
	logic signed [9:0] position;
	logic              direction_forward;
	logic              moving;
	logic              arrived;

	modport source (output valid, position, direction_forward, moving, arrived, input ready);
	modport sink   (input valid, position, direction_forward, moving, arrived, output ready);
endinterface

>>> src/pap_cfg_if.sv
// ----------------------------------------------------------------------------
// pap_cfg_if: configuration write channel
// Carries a register index and write data, with valid and ready.
// ----------------------------------------------------------------------------
interface pap_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [9:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> src/pap_cfg_regs.sv
// ----------------------------------------------------------------------------
// pap_cfg_regs: configuration register bank
// Decodes write beats into the range mode and the two range bounds.
// ----------------------------------------------------------------------------
module pap_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	pap_cfg_if.sink             cfg_wr,
	output pap_pkg::axis_cfg_t  cfg
);

	pap_pkg::axis_cfg_t cfg_q;

	assign cfg_wr.ready = 1'b1;
	assign cfg          = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limited <= 1'b0;
			cfg_q.low     <= pap_pkg::RANGE_LOW_RST;
			cfg_q.high    <= pap_pkg::RANGE_HIGH_RST;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				pap_pkg::REG_LIMITED_MODE: cfg_q.limited <= cfg_wr.data[0];
				pap_pkg::REG_RANGE_LOW:    cfg_q.low     <= pap_pkg::pos_t'(cfg_wr.data);
				pap_pkg::REG_RANGE_HIGH:   cfg_q.high    <= pap_pkg::pos_t'(cfg_wr.data);
				default: ;
			endcase
		end
	end

endmodule

>>> src/pap_step.sv
// ----------------------------------------------------------------------------
// pap_step: next-state logic of the axis
// Applies one event to the axis state and forms the status beat.
// ----------------------------------------------------------------------------
module pap_step (
	input  pap_pkg::axis_state_t cur,
	input  pap_pkg::axis_cfg_t   cfg,
	input  logic [3:0]           kind,
	input  pap_pkg::pos_t        move_value,
	output pap_pkg::axis_state_t nxt,
	output pap_pkg::status_t     status
);

	logic          adv_fwd;
	logic          adv_en;
	logic          arrived;
	pap_pkg::wide_t adv_next;
	pap_pkg::pos_t  adv_pos;
	pap_pkg::wide_t sum;
	pap_pkg::pos_t  tgt_wrap;
	pap_pkg::pos_t  tgt_lim;
	pap_pkg::pos_t  by_wrap;
	pap_pkg::pos_t  by_lim;
	pap_pkg::pos_t  delta_wrap;

	// Step events set the heading before the advance
	always_comb begin
		adv_fwd = cur.heading_fwd;
		if (kind == pap_pkg::KIND_STEP_FWD)  adv_fwd = 1'b1;
		if (kind == pap_pkg::KIND_STEP_BACK) adv_fwd = 1'b0;
	end

	always_comb begin
		adv_next = pap_pkg::wide_t'(cur.position) + (adv_fwd ? 12'sd1 : -12'sd1);
		if (cfg.limited) begin
			// skip a step that would leave the range
			if (adv_next >= pap_pkg::wide_t'(cfg.low) &&
					adv_next <= pap_pkg::wide_t'(cfg.high))
				adv_pos = pap_pkg::pos_t'(adv_next[pap_pkg::POS_W-1:0]);
			else
				adv_pos = cur.position;
		end else begin
			adv_pos = pap_pkg::wrap360(adv_next);
		end
	end

	assign sum        = pap_pkg::wide_t'(cur.position) + pap_pkg::wide_t'(move_value);
	assign tgt_wrap   = pap_pkg::wrap360(pap_pkg::wide_t'(move_value));
	assign tgt_lim    = pap_pkg::clamp_range(pap_pkg::wide_t'(move_value), cfg.low, cfg.high);
	assign by_wrap    = pap_pkg::wrap360(sum);
	assign by_lim     = pap_pkg::clamp_range(sum, cfg.low, cfg.high);
	assign delta_wrap = pap_pkg::wrap360(pap_pkg::wide_t'(tgt_wrap) -
		pap_pkg::wide_t'(cur.position));

	always_comb begin
		nxt     = cur;
		adv_en  = 1'b0;
		arrived = 1'b0;
		unique case (kind) inside
			pap_pkg::KIND_TICK: begin
				if (cur.mode == pap_pkg::MODE_CONT) begin
					adv_en = 1'b1;
				end else if (cur.mode == pap_pkg::MODE_MOVETO) begin
					if (cur.position == cur.target) begin
						nxt.mode = pap_pkg::MODE_IDLE;
						arrived  = 1'b1;
					end else begin
						adv_en = 1'b1;
					end
				end
			end
			pap_pkg::KIND_MOVE_TO: begin
				if (cfg.limited) begin
					nxt.target      = tgt_lim;
					nxt.heading_fwd = tgt_lim > cur.position;
				end else begin
					nxt.target      = tgt_wrap;
					nxt.heading_fwd = pap_pkg::wide_t'(delta_wrap) < pap_pkg::HALF_TURN;
				end
				nxt.mode = pap_pkg::MODE_MOVETO;
			end
			pap_pkg::KIND_MOVE_BY: begin
				if (cfg.limited) begin
					nxt.target      = by_lim;
					nxt.heading_fwd = by_lim > cur.position;
				end else begin
					nxt.target      = by_wrap;
					nxt.heading_fwd = move_value > 10'sd0;
				end
				nxt.mode = pap_pkg::MODE_MOVETO;
			end
			pap_pkg::KIND_RUN:  nxt.mode = pap_pkg::MODE_CONT;
			pap_pkg::KIND_STOP: nxt.mode = pap_pkg::MODE_IDLE;
			pap_pkg::KIND_STEP_BACK, pap_pkg::KIND_STEP_FWD: begin
				nxt.heading_fwd = adv_fwd;
				adv_en          = 1'b1;
			end
			pap_pkg::KIND_DIR_FWD:  nxt.heading_fwd = 1'b1;
			pap_pkg::KIND_DIR_BACK: nxt.heading_fwd = 1'b0;
			default: ;
		endcase
		if (adv_en) nxt.position = adv_pos;
	end

	assign status.position          = nxt.position;
	assign status.direction_forward = nxt.heading_fwd;
	assign status.moving            = nxt.mode != pap_pkg::MODE_IDLE;
	assign status.arrived           = arrived;

endmodule

>>> src/pan_axis_positioner_unit.sv
// ----------------------------------------------------------------------------
// pan_axis_positioner_unit: simulated pan or tilt axis
// Takes axis events, moves one degree per tick and reports status per event.
// ----------------------------------------------------------------------------
// Each event beat on item_in yields exactly one status beat on status_out.
// An event is captured in an input register, applied to the axis state by a
// single pass of add, compare and wrap-by-360 logic, and the resulting status
// is held in an output register; the state update and the status capture
// happen in the same cycle. Throughput is one event per clock while the
// status channel does not stall. A new event is taken while a finished
// status still waits, as long as the input register can move on.
// Configuration writes on cfg_wr are always ready and take effect on the
// next cycle; write only while no event is in flight. Kinds outside the
// defined set leave the state alone but still report status.
module pan_axis_positioner_unit (
	input  logic    clk,
	input  logic    arst_n,
	pap_in_if.sink  item_in,
	pap_out_if.source status_out,
	pap_cfg_if.sink cfg_wr
);

	pap_pkg::axis_cfg_t   cfg;
	pap_pkg::axis_state_t state_q;
	pap_pkg::axis_state_t state_nxt;
	pap_pkg::status_t     status_nxt;
	pap_pkg::status_t     status_q;

	// input stage
	logic          valid_s1;
	logic [3:0]    kind_s1;
	pap_pkg::pos_t move_value_s1;

	logic out_valid_q;
	logic advance_s1;

	pap_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.cfg    (cfg)
	);

	pap_step u_step (
		.cur        (state_q),
		.cfg        (cfg),
		.kind       (kind_s1),
		.move_value (move_value_s1),
		.nxt        (state_nxt),
		.status     (status_nxt)
	);

	// Advance the input stage when the result register is free or draining
	assign advance_s1    = valid_s1 && (!out_valid_q || status_out.ready);
	assign item_in.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.valid && item_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the event payload until the stage moves on
	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			kind_s1       <= item_in.kind;
			move_value_s1 <= item_in.move_value;
		end
	end

	// Commit the axis state together with the status beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.position    <= '0;
			state_q.target      <= '0;
			state_q.heading_fwd <= 1'b0;
			state_q.mode        <= pap_pkg::MODE_IDLE;
			out_valid_q         <= 1'b0;
		end else if (advance_s1) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (status_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			status_q <= status_nxt;
		end
	end

	assign status_out.valid             = out_valid_q;
	assign status_out.position          = status_q.position;
	assign status_out.direction_forward = status_q.direction_forward;
	assign status_out.moving            = status_q.moving;
	assign status_out.arrived           = status_q.arrived;

endmodule

>>> verif/pan_axis_positioner_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pan_axis_positioner_unit_test: self-checking bench for the pan axis unit
// Sends event beats in random bursts against a stalling status sink. Each
// status beat is checked field by field against a behavioural model of the
// axis, in wrap mode and in limited mode, including flat and crossed ranges.
// ----------------------------------------------------------------------------
module pan_axis_positioner_unit_test;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DEG_FULL    = 360;
	localparam int DEG_HALF    = 180;
	localparam int MOVE_MAX    = 360;

	// No event is defined for this code: the unit must leave its state alone
	localparam logic [3:0] KIND_UNUSED = 4'hF;

	// Styles of back-pressure on the status channel
	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN, RX_LONG} rx_style_t;

	logic clk = 1'b0;
	logic arst_n;

	pap_in_if  evt_if ();
	pap_out_if sts_if ();
	pap_cfg_if cfg_if ();

	pan_axis_positioner_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (evt_if),
		.status_out(sts_if),
		.cfg_wr    (cfg_if)
	);

	// Axis model: configuration as last written, state as after the last
	// accepted event beat
	logic           m_limited;
	int             m_low;
	int             m_high;
	int             m_pos;
	int             m_target;
	logic           m_fwd;
	pap_pkg::mode_t m_mode;

	// Status beats owed by the unit, oldest first
	pap_pkg::status_t pending_status[$];

	int   mismatches  = 0;
	int   items_sent  = 0;
	int   cycle_count = 0;

	// Sender burst shaping; steady suppresses gaps for a stretch
	int   burst_left = 0;
	logic steady     = 1'b0;

	// Receiver stall pattern
	rx_style_t  rx_style = RX_FREE;
	int         rx_span  = 0;
	int         rx_hold  = 0;
	logic [7:0] rx_rot   = 8'b1011_0110;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Axis model
	// ------------------------------------------------------------------

	function automatic int turn_mod(input int v);
		int r;
		r = v % DEG_FULL;
		if (r < 0) r += DEG_FULL;
		return r;
	endfunction

	// Apply the top bound first, then the bottom: a crossed range pins to low
	function automatic int pin_to_range(input int v);
		int r;
		r = (v > m_high) ? m_high : v;
		return (r < m_low) ? m_low : r;
	endfunction

	// One degree along the heading; in limited mode skip a step that would
	// leave the range, in wrap mode fold back into 0..359
	function automatic void step_axis();
		int nxt;
		nxt = m_pos + (m_fwd ? 1 : -1);
		if (m_limited) begin
			if (nxt >= m_low && nxt <= m_high) m_pos = nxt;
		end else begin
			m_pos = turn_mod(nxt);
		end
	endfunction

	function automatic pap_pkg::status_t apply_event(input logic [3:0] k, input int mv);
		pap_pkg::status_t s;
		logic             hit;
		hit = 1'b0;
		case (k)
			pap_pkg::KIND_TICK: begin
				if (m_mode == pap_pkg::MODE_CONT) begin
					step_axis();
				end else if (m_mode == pap_pkg::MODE_MOVETO) begin
					// Arrival is seen on the tick after the last step
					if (m_pos == m_target) begin
						m_mode = pap_pkg::MODE_IDLE;
						hit    = 1'b1;
					end else begin
						step_axis();
					end
				end
			end
			pap_pkg::KIND_MOVE_TO: begin
				if (m_limited) begin
					m_target = pin_to_range(mv);
					m_fwd    = (m_target > m_pos);
				end else begin
					// Take the shorter way; exactly half a turn goes backward
					m_target = turn_mod(mv);
					m_fwd    = (turn_mod(m_target - m_pos) < DEG_HALF);
				end
				m_mode = pap_pkg::MODE_MOVETO;
			end
			pap_pkg::KIND_MOVE_BY: begin
				if (m_limited) begin
					m_target = pin_to_range(m_pos + mv);
					m_fwd    = (m_target > m_pos);
				end else begin
					m_target = turn_mod(m_pos + mv);
					m_fwd    = (mv > 0);
				end
				m_mode = pap_pkg::MODE_MOVETO;
			end
			pap_pkg::KIND_RUN:  m_mode = pap_pkg::MODE_CONT;
			pap_pkg::KIND_STOP: m_mode = pap_pkg::MODE_IDLE;
			pap_pkg::KIND_STEP_BACK: begin
				m_fwd = 1'b0;
				step_axis();
			end
			pap_pkg::KIND_STEP_FWD: begin
				m_fwd = 1'b1;
				step_axis();
			end
			pap_pkg::KIND_DIR_FWD:  m_fwd = 1'b1;
			pap_pkg::KIND_DIR_BACK: m_fwd = 1'b0;
			default: ;
		endcase
		s.position          = m_pos[pap_pkg::POS_W-1:0];
		s.direction_forward = m_fwd;
		s.moving            = (m_mode != pap_pkg::MODE_IDLE);
		s.arrived           = hit;
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------

	function automatic int any_value();
		return int'($urandom_range(0, 2 * MOVE_MAX)) - MOVE_MAX;
	endfunction

	// Drive one event beat and hold it until accepted. Valid is left high
	// so that back-to-back beats never drop it within a time step.
	task automatic send_event(input logic [3:0] k, input int mv);
		int gap;
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = $urandom_range(0, 7);
			if (gap != 0) begin
				evt_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left != 0) burst_left--;
		evt_if.valid      <= 1'b1;
		evt_if.kind       <= k;
		evt_if.move_value <= mv[pap_pkg::POS_W-1:0];
		do @(posedge clk); while (evt_if.ready !== 1'b1);
		pending_status.push_back(apply_event(k, mv));
		items_sent++;
	endtask

	task automatic send_noise();
		send_event(4'($urandom_range(0, 8)), any_value());
	endtask

	// Hold off the sender until every owed status beat has arrived, then
	// let the pipeline run dry
	task automatic settle_axis();
		evt_if.valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input pap_pkg::reg_idx_t idx, input int value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value[pap_pkg::POS_W-1:0];
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		case (idx)
			pap_pkg::REG_LIMITED_MODE: m_limited = value[0];
			pap_pkg::REG_RANGE_LOW:    m_low     = value;
			pap_pkg::REG_RANGE_HIGH:   m_high    = value;
			default: ;
		endcase
	endtask

	// Write all three registers back to back; only call while settled
	task automatic configure_axis(input logic lim, input int lo, input int hi);
		write_reg(pap_pkg::REG_LIMITED_MODE, lim);
		write_reg(pap_pkg::REG_RANGE_LOW, lo);
		write_reg(pap_pkg::REG_RANGE_HIGH, hi);
		cfg_if.valid <= 1'b0;
	endtask

	// Start a move and tick until the model says it has arrived or the cap
	// runs out; with noisy set, stray events sometimes break in
	task automatic run_move(input logic [3:0] k, input int mv, input int cap,
			input logic noisy);
		int n;
		send_event(k, mv);
		n = 0;
		while (m_mode == pap_pkg::MODE_MOVETO && n < cap) begin
			if (noisy && $urandom_range(0, 15) == 0) send_noise();
			else send_event(pap_pkg::KIND_TICK, any_value());
			n++;
		end
	endtask

	// Mostly well-formed moves and runs with random content, plus steps,
	// cut-short sequences and stray events
	task automatic random_traffic(input int n_items, input int reach);
		int stop_at;
		int mv;
		int pick;
		int cap;
		int n;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			steady = ($urandom_range(0, 4) == 0);
			pick   = $urandom_range(0, 9);
			if (pick <= 4) begin
				if ($urandom_range(0, 9) == 0) begin
					mv  = any_value();
					cap = 400;
				end else begin
					mv  = int'($urandom_range(0, 2 * reach)) - reach;
					cap = 3 * reach + 8;
				end
				// cut a quarter of the moves short
				if ($urandom_range(0, 3) == 0) cap = $urandom_range(0, reach);
				if ($urandom_range(0, 1) == 0) begin
					mv = mv + m_pos;
					if (mv > MOVE_MAX)  mv = MOVE_MAX;
					if (mv < -MOVE_MAX) mv = -MOVE_MAX;
					run_move(pap_pkg::KIND_MOVE_TO, mv, cap, 1'b1);
				end else begin
					run_move(pap_pkg::KIND_MOVE_BY, mv, cap, 1'b1);
				end
			end else if (pick <= 6) begin
				send_event(pap_pkg::KIND_RUN, any_value());
				n = $urandom_range(0, 20);
				repeat (n) begin
					if ($urandom_range(0, 7) == 0)
						send_event($urandom_range(0, 1) ?
							pap_pkg::KIND_DIR_FWD : pap_pkg::KIND_DIR_BACK,
							any_value());
					else
						send_event(pap_pkg::KIND_TICK, any_value());
				end
				send_event(pap_pkg::KIND_STOP, any_value());
			end else if (pick == 7) begin
				n = $urandom_range(1, 8);
				repeat (n)
					send_event($urandom_range(0, 1) ?
						pap_pkg::KIND_STEP_FWD : pap_pkg::KIND_STEP_BACK,
						any_value());
			end else begin
				send_noise();
			end
			if ($urandom_range(0, 39) == 0) settle_axis();
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Wrap mode from reset: folding at 0 and 359, the half-turn tie, full-turn
	// targets, every event kind and an undefined one
	task automatic test_wrap_edges();
		send_event(pap_pkg::KIND_TICK, 0);            // idle: nothing moves
		send_event(pap_pkg::KIND_STEP_BACK, 0);       // fold under zero to 359
		send_event(pap_pkg::KIND_STEP_FWD, 0);        // and back over 359 to 0
		send_event(pap_pkg::KIND_DIR_FWD, 0);
		send_event(pap_pkg::KIND_DIR_BACK, 0);
		send_event(pap_pkg::KIND_MOVE_TO, 180);       // tie on the way round: go backward
		send_event(pap_pkg::KIND_TICK, 0);
		send_event(pap_pkg::KIND_STOP, 0);
		send_event(pap_pkg::KIND_MOVE_TO, -360);      // folds to 0, one degree ahead
		send_event(pap_pkg::KIND_TICK, 0);
		send_event(pap_pkg::KIND_TICK, 0);            // arrival flagged here
		send_event(pap_pkg::KIND_MOVE_BY, 360);       // full turn: target is here, forward
		send_event(pap_pkg::KIND_TICK, 0);
		send_event(pap_pkg::KIND_RUN, 0);
		send_event(pap_pkg::KIND_TICK, 0);
		send_event(pap_pkg::KIND_STOP, 0);
		send_event(KIND_UNUSED, 0);
	endtask

	// Limited mode: targets clamped at both ends of the widest range, steps
	// skipped at a single-point range, and a crossed range where low wins
	task automatic test_limited_edges();
		settle_axis();
		configure_axis(1'b1, -180, 359);
		send_event(pap_pkg::KIND_MOVE_TO, 360);
		send_event(pap_pkg::KIND_MOVE_BY, -360);
		settle_axis();
		configure_axis(1'b1, m_pos, m_pos);
		send_event(pap_pkg::KIND_STEP_FWD, 0);
		send_event(pap_pkg::KIND_STEP_BACK, 0);
		settle_axis();
		configure_axis(1'b1, 5, -5);
		send_event(pap_pkg::KIND_MOVE_TO, 100);
		send_event(pap_pkg::KIND_TICK, 0);
		send_event(pap_pkg::KIND_STOP, 0);
	endtask

	task automatic test_random_wrap();
		settle_axis();
		configure_axis(1'b0, -180, 180);
		random_traffic(220, 30);
	endtask

	task automatic test_random_limited_wide();
		settle_axis();
		configure_axis(1'b1, -180, 359);
		random_traffic(150, 40);
	endtask

	// Home to zero inside the wide range first so the narrow range starts
	// with the axis inside it, then finish parked on the (negative) low end
	task automatic test_random_limited_narrow();
		run_move(pap_pkg::KIND_MOVE_TO, 0, 600, 1'b0);
		settle_axis();
		configure_axis(1'b1, -int'($urandom_range(1, 20)), $urandom_range(0, 25));
		random_traffic(140, 12);
		run_move(pap_pkg::KIND_MOVE_TO, m_low, 100, 1'b0);
	endtask

	// Ranges that freeze the axis: a single point, then the extremes crossed
	task automatic test_frozen_ranges();
		settle_axis();
		configure_axis(1'b1, m_pos, m_pos);
		random_traffic(30, 6);
		settle_axis();
		configure_axis(1'b1, 359, -180);
		random_traffic(30, 6);
	endtask

	// Back to wrap mode with the axis possibly below zero
	task automatic test_return_to_wrap();
		settle_axis();
		configure_axis(1'b0, pap_pkg::RANGE_LOW_RST, pap_pkg::RANGE_HIGH_RST);
		random_traffic(130, 30);
	endtask

	// ------------------------------------------------------------------
	// Status sink and checking
	// ------------------------------------------------------------------

	// Stall the status channel in changing styles: free running, random,
	// a rotating pattern, and long holds
	always @(posedge clk) begin
		rx_rot <= {rx_rot[6:0], rx_rot[7]};
		if (rx_span == 0) begin
			rx_style <= rx_style_t'($urandom_range(0, 3));
			rx_span  <= $urandom_range(32, 200);
		end else begin
			rx_span <= rx_span - 1;
		end
		case (rx_style)
			RX_FREE:    sts_if.ready <= 1'b1;
			RX_RANDOM:  sts_if.ready <= ($urandom_range(0, 3) != 0);
			RX_PATTERN: sts_if.ready <= rx_rot[0];
			default: begin
				if (rx_hold != 0) begin
					sts_if.ready <= 1'b0;
					rx_hold      <= rx_hold - 1;
				end else begin
					sts_if.ready <= 1'b1;
					if ($urandom_range(0, 5) == 0) rx_hold <= $urandom_range(4, 12);
				end
			end
		endcase
	end

	// Print one line for the mismatch and count it
	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin : check_status
		pap_pkg::status_t want;
		if (sts_if.valid === 1'b1 && sts_if.ready === 1'b1) begin
			if (pending_status.size() == 0) begin
				flag_mismatch("status beat with nothing owed", sts_if.position, 0);
			end else begin
				want = pending_status.pop_front();
				if (sts_if.position !== want.position)
					flag_mismatch("position", sts_if.position, want.position);
				if (sts_if.direction_forward !== want.direction_forward)
					flag_mismatch("direction_forward", sts_if.direction_forward,
						want.direction_forward);
				if (sts_if.moving !== want.moving)
					flag_mismatch("moving", sts_if.moving, want.moving);
				if (sts_if.arrived !== want.arrived)
					flag_mismatch("arrived", sts_if.arrived, want.arrived);
			end
		end
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n            = 1'b0;
		evt_if.valid      = 1'b0;
		evt_if.kind       = pap_pkg::KIND_TICK;
		evt_if.move_value = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = pap_pkg::REG_LIMITED_MODE;
		cfg_if.data       = '0;
		sts_if.ready      = 1'b0;

		m_limited = 1'b0;
		m_low     = pap_pkg::RANGE_LOW_RST;
		m_high    = pap_pkg::RANGE_HIGH_RST;
		m_pos     = 0;
		m_target  = 0;
		m_fwd     = 1'b0;
		m_mode    = pap_pkg::MODE_IDLE;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_wrap_edges();
		test_limited_edges();
		test_random_wrap();
		test_random_limited_wide();
		test_random_limited_narrow();
		test_frozen_ranges();
		test_return_to_wrap();
		settle_axis();

		if (mismatches == 0 && pending_status.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
